>>> rtl/core/stbs_pkg.sv
// shared types and constants for the sorted table binary search unit
// no dependencies; imported by stbs_ctrl, stbs_dp and the top level
package stbs_pkg;

  // field widths of the transaction ports
  localparam int IDX_W  = 10;
  localparam int DATA_W = 32;
  localparam int CNT_W  = 11;

  // default table size
  localparam int TABLE_DEPTH_DEF = 1024;

  // operation codes carried on in_func
  typedef enum logic {
    FUNC_LOAD   = 1'b0,
    FUNC_SEARCH = 1'b1
  } stbs_func_t;

  // controller to datapath commands
  typedef struct packed {
    logic load_wr;
    logic search_start;
    logic probe;
    logic out_load;
  } stbs_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic empty;
    logic hit;
    logic more;
  } stbs_sts_t;

endpackage

>>> rtl/core/stbs_ctrl.sv
// control state machine of the binary search unit
// depends on stbs_pkg for the command and status structs
module stbs_ctrl
  import stbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_func,
  output logic      out_valid,
  input  logic      out_ready,
  output stbs_cmd_t cmd,
  input  stbs_sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_PROBE  = 3'b010,
    ST_RESULT = 3'b100
  } stbs_state_t;

  stbs_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;

  // input handshake
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // next state and commands
  always_comb begin
    state_nxt        = state_r;
    cmd.load_wr      = accept && (in_func == FUNC_LOAD);
    cmd.search_start = accept && (in_func == FUNC_SEARCH);
    cmd.probe        = 1'b0;
    cmd.out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd.search_start) begin
          state_nxt = sts.empty ? ST_RESULT : ST_PROBE;
        end
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        if (sts.hit || !sts.more) begin
          state_nxt = ST_RESULT;
        end
      end
      ST_RESULT: begin
        cmd.out_load = !out_valid_r || out_ready;
        if (cmd.out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output valid flag
  always_comb begin
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> rtl/core/stbs_dp.sv
// datapath of the binary search unit: table memory, bounds, compare, result
// depends on stbs_pkg for widths and the command and status structs
module stbs_dp
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_wdata,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_entry_value,
  input  logic signed [DATA_W-1:0] in_search_key,
  input  stbs_cmd_t                cmd,
  output stbs_sts_t                sts,
  output logic                     out_found,
  output logic [IDX_W-1:0]         out_match_index
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int PW = AW + 1;
  localparam int SW = (PW > CNT_W) ? PW : CNT_W;
  localparam int XW = ((AW > IDX_W) ? AW : IDX_W) + 1;
  localparam logic [PW-1:0] ONE_P = PW'(1);

  logic signed [DATA_W-1:0] mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rdata_r;
  logic signed [DATA_W-1:0] key_r;
  logic [CNT_W-1:0]         entry_count_r;
  logic [PW-1:0]            lo_r, hx_r;
  logic [AW-1:0]            mid_r;
  logic                     res_found_r;
  logic [IDX_W-1:0]         res_index_r;
  logic                     out_found_r;
  logic [IDX_W-1:0]         out_index_r;

  logic [XW-1:0] idx_ext;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] cnt_ext;
  logic [PW-1:0] sat_cnt;
  logic [AW-1:0] mid0;
  logic [PW-1:0] mid_ext, mid_p1, mid_g, mid_l;
  logic [AW-1:0] mid_next;
  logic [AW-1:0] rd_addr;
  logic          gt, hit;

  // entry count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r <= '0;
    end else if (cfg_we) begin
      entry_count_r <= cfg_wdata;
    end
  end

  // load address check
  assign idx_ext = XW'(in_entry_index);
  assign wr_en   = cmd.load_wr && (idx_ext < XW'(TABLE_DEPTH));
  assign wr_addr = AW'(idx_ext);

  // count clamped to the table size, first midpoint
  assign cnt_ext = SW'(entry_count_r);
  assign sat_cnt = (cnt_ext > SW'(TABLE_DEPTH)) ? PW'(TABLE_DEPTH) : PW'(cnt_ext);
  assign mid0    = AW'((sat_cnt - ONE_P) >> 1);

  // compare probed entry against key
  assign gt  = key_r > rdata_r;
  assign hit = key_r == rdata_r;

  // both candidate next midpoints, chosen by the compare
  assign mid_ext  = PW'(mid_r);
  assign mid_p1   = mid_ext + ONE_P;
  assign mid_g    = mid_p1 + ((hx_r - mid_p1 - ONE_P) >> 1);
  assign mid_l    = lo_r + ((mid_ext - lo_r - ONE_P) >> 1);
  assign mid_next = gt ? AW'(mid_g) : AW'(mid_l);
  assign rd_addr  = cmd.search_start ? mid0 : mid_next;

  // status to the controller
  assign sts.empty = (sat_cnt == '0);
  assign sts.hit   = hit;
  assign sts.more  = gt ? (mid_p1 < hx_r) : (lo_r < mid_ext);

  // table memory with registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= in_entry_value;
    end
    rdata_r <= mem[rd_addr];
  end

  // search bounds and result
  always_ff @(posedge clk) begin
    if (cmd.search_start) begin
      key_r       <= in_search_key;
      lo_r        <= '0;
      hx_r        <= sat_cnt;
      mid_r       <= mid0;
      res_found_r <= 1'b0;
      res_index_r <= '0;
    end else if (cmd.probe) begin
      if (gt) begin
        lo_r <= mid_p1;
      end else begin
        hx_r <= mid_ext;
      end
      mid_r       <= mid_next;
      res_found_r <= hit;
      res_index_r <= hit ? IDX_W'(mid_r) : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_found_r <= res_found_r;
      out_index_r <= res_index_r;
    end
  end

  assign out_found       = out_found_r;
  assign out_match_index = out_index_r;

endmodule

>>> rtl/core/sorted_table_binary_search_unit.sv
// sorted table binary search unit: table of signed 32-bit words with search
// in_* channel: valid/ready; in_func selects a load (entry_index, entry_value)
//   or a search (search_key) over the first entry_count entries
// out_* channel: valid/ready; one transaction per search (found, match_index),
//   match_index is 0 when nothing matched; loads give no output transaction
// cfg_we/cfg_wdata: writes entry_count; the user must write it only while the
//   unit is idle, the unit itself does not enforce this; a load is written when
//   accepted; a search starts its first table read when accepted, then makes its
//   memory probes (at most log2(TABLE_DEPTH)+1, 11 at 1024 entries) and moves the
//   result to the output register; throughput is set by the single read port of
//   the table memory, one probe per cycle, and one search in flight at a time
// reset: entry_count clears to 0 and no output is pending; table contents are
//   undefined until loaded, no clearing pass
// receiver stall: a finished result waits in the output register while new
//   loads and the next search are taken; a second result waits in the
//   datapath until the output register frees
// depends on stbs_pkg, stbs_ctrl and stbs_dp
module sorted_table_binary_search_unit
  import stbs_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CNT_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_func,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_entry_value,
  input  logic signed [DATA_W-1:0] in_search_key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     out_found,
  output logic [IDX_W-1:0]         out_match_index
);

  stbs_cmd_t cmd;
  stbs_sts_t sts;

  // control state machine
  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_func   (in_func),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table memory and search datapath
  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_search_key   (in_search_key),
    .cmd             (cmd),
    .sts             (sts),
    .out_found       (out_found),
    .out_match_index (out_match_index)
  );

endmodule

>>> tb/sorted_table_binary_search_unit_test.sv
// self-checking testbench for the sorted table binary search unit
// loads and searches through valid/ready with random gaps and stalls, predicts each search
// depends on stbs_pkg and sorted_table_binary_search_unit
`timescale 1ns / 100ps

module sorted_table_binary_search_unit_test;
  import stbs_pkg::*;

  localparam int DEPTH = TABLE_DEPTH_DEF;
  localparam int RANDOM_OPS = 1100;
  localparam int CYCLE_LIMIT = 800000;
  localparam int DRAIN_CYCLES = 16;
  localparam logic signed [DATA_W-1:0] WORD_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] WORD_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  // one input transaction
  typedef struct {
    stbs_func_t               func;
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] value;
    logic signed [DATA_W-1:0] key;
  } table_op_t;

  // one search outcome
  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] index;
  } lookup_t;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_we = 1'b0;
  logic [CNT_W-1:0]         cfg_wdata = '0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     in_func = 1'b0;
  logic [IDX_W-1:0]         in_entry_index = '0;
  logic signed [DATA_W-1:0] in_entry_value = '0;
  logic signed [DATA_W-1:0] in_search_key = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_found;
  logic [IDX_W-1:0]         out_match_index;

  // pending transactions, expected search outcomes
  table_op_t pend_q[$];
  lookup_t   lookup_q[$];

  // table and entry count as the unit should hold them
  logic signed [DATA_W-1:0] model_tbl [DEPTH];
  logic [CNT_W-1:0]         model_count = '0;

  // table contents in queue order, used to pick keys
  logic signed [DATA_W-1:0] gen_tbl [DEPTH];

  table_op_t in_cur;
  int        in_gap = 0;
  int        out_wait = 0;
  int        hold_req = 0;
  bit        in_idle = 1'b1;
  bit        out_idle = 1'b1;
  int        tally = 0;
  int        errors = 0;
  int        cycles = 0;

  sorted_table_binary_search_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_func         (in_func),
    .in_entry_index  (in_entry_index),
    .in_entry_value  (in_entry_value),
    .in_search_key   (in_search_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_found       (out_found),
    .out_match_index (out_match_index)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // binary search over the in-use entries, first matching midpoint wins
  function automatic lookup_t search_table(logic signed [DATA_W-1:0] key);
    int lo, hi, mid, n;
    lookup_t r;
    n = (model_count > DEPTH) ? DEPTH : int'(model_count);
    lo = 0;
    hi = n - 1;
    r.found = 1'b0;
    r.index = '0;
    while (lo <= hi && !r.found) begin
      mid = lo + (hi - lo) / 2;
      if (key == model_tbl[mid]) begin
        r.found = 1'b1;
        r.index = mid[IDX_W-1:0];
      end else if (key > model_tbl[mid]) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  // update the table or queue an expected outcome for an accepted transaction
  task automatic absorb_op(table_op_t op);
    if (op.func == FUNC_LOAD) model_tbl[op.idx] = op.value;
    else lookup_q.push_back(search_table(op.key));
  endtask

  // input driver
  always @(posedge clk) begin : in_driver
    logic offering;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      offering = in_valid;
      if (in_valid && in_ready) begin
        absorb_op(in_cur);
        offering = 1'b0;
        in_gap = in_idle ? $urandom_range(0, 13) : 0;
      end
      if (!offering) begin
        if (in_gap != 0) begin
          in_gap--;
        end else if (pend_q.size() != 0) begin
          in_cur = pend_q.pop_front();
          in_func <= in_cur.func;
          in_entry_index <= in_cur.idx;
          in_entry_value <= in_cur.value;
          in_search_key <= in_cur.key;
          offering = 1'b1;
        end
      end
      in_valid <= offering;
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin : out_monitor
    lookup_t want;
    logic take;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (lookup_q.size() == 0) begin
          errors++;
          $display("%0t: result found=%0d index=%0d, expected none", $time, out_found,
                   out_match_index);
        end else begin
          want = lookup_q.pop_front();
          if (out_found !== want.found) begin
            errors++;
            $display("%0t: found expected %0d, got %0d", $time, want.found, out_found);
          end
          if (out_match_index !== want.index) begin
            errors++;
            $display("%0t: match_index expected %0d, got %0d", $time, want.index,
                     out_match_index);
          end
        end
        out_wait = out_idle ? $urandom_range(0, 13) : 0;
      end
      // long hold-off requested by the stimulus
      if (hold_req != 0) begin
        out_wait = hold_req;
        hold_req = 0;
      end
      take = (out_wait == 0);
      if (out_wait != 0) out_wait--;
      out_ready <= take;
    end
  end

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("sorted_table_binary_search_unit: mismatch");
      $finish;
    end
  end

  task automatic queue_load(int idx, logic signed [DATA_W-1:0] val);
    table_op_t op;
    op.func = FUNC_LOAD;
    op.idx = idx[IDX_W-1:0];
    op.value = val;
    op.key = $urandom;
    pend_q.push_back(op);
    gen_tbl[idx] = val;
    tally++;
  endtask

  task automatic queue_search(logic signed [DATA_W-1:0] key);
    table_op_t op;
    op.func = FUNC_SEARCH;
    op.idx = IDX_W'($urandom_range(0, DEPTH - 1));
    op.value = $urandom;
    op.key = key;
    pend_q.push_back(op);
    tally++;
  endtask

  // wait until no transaction is pending or expected, then let the unit go quiet
  task automatic settle();
    @(negedge clk);
    while (pend_q.size() != 0 || in_valid || lookup_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_entry_count(logic [CNT_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    model_count = v;
    @(negedge clk);
  endtask

  // ascending table of n entries, dense runs give duplicates
  task automatic fill_sorted(int n);
    longint level;
    int unsigned stepmax;
    bit top;
    int i;
    top = 1'b0;
    if ($urandom_range(0, 2) == 0) begin
      level = -64'sd2147483648;
      stepmax = 32'hFFFF_FFFF / (n + 1);
      top = ($urandom_range(0, 1) == 0);
    end else begin
      level = longint'($signed($urandom)) / 2;
      stepmax = ($urandom_range(0, 2) == 0) ? 2 : 32'h7FFF_FFFF / (n + 1);
    end
    for (i = 0; i < n; i++) begin
      if (top && i == n - 1) level = 64'sd2147483647;
      if (level > 64'sd2147483647) level = 64'sd2147483647;
      queue_load(i, level[DATA_W-1:0]);
      level += longint'($urandom_range(0, stepmax));
    end
  endtask

  // present keys, near misses, extremes and random keys
  function automatic logic signed [DATA_W-1:0] pick_key(int n);
    int i;
    logic signed [DATA_W-1:0] k;
    i = (n > 0) ? $urandom_range(0, n - 1) : 0;
    k = $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: if (n > 0) k = gen_tbl[i];
      3: if (n > 0) k = gen_tbl[i] + 1;
      4: if (n > 0) k = gen_tbl[i] - 1;
      5: k = WORD_MIN;
      6: k = WORD_MAX;
      default: ;
    endcase
    return k;
  endfunction

  // searches with a sprinkling of stray loads, some of which unsort the table
  task automatic run_searches(int n, int hits);
    int j, n_eff, idx;
    n_eff = (n > DEPTH) ? DEPTH : n;
    for (j = 0; j < hits; j++) begin
      if ($urandom_range(0, 7) == 0) begin
        idx = (n_eff < DEPTH && $urandom_range(0, 4) != 0) ?
              $urandom_range(n_eff, DEPTH - 1) : $urandom_range(0, DEPTH - 1);
        queue_load(idx, $urandom);
      end
      queue_search(pick_key(n_eff));
    end
  endtask

  initial begin : stimulus
    int phase, n;
    for (int i = 0; i < DEPTH; i++) begin
      model_tbl[i] = '0;
      gen_tbl[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty table
    set_entry_count('0);
    queue_search('0);
    queue_search(WORD_MIN);
    settle();

    // small table with extremes and duplicate runs, top index loaded too
    queue_load(0, WORD_MIN);
    queue_load(1, -5);
    queue_load(2, -5);
    queue_load(3, 0);
    queue_load(4, 7);
    queue_load(5, 7);
    queue_load(6, 7);
    queue_load(7, WORD_MAX);
    queue_load(DEPTH - 1, 32'h5A5A_A5A5);
    settle();
    set_entry_count(CNT_W'(8));
    queue_search(WORD_MIN);
    queue_search(WORD_MAX);
    queue_search(-5);
    queue_search(7);
    queue_search(3);
    queue_search(-6);
    queue_search(WORD_MAX - 1);
    queue_search(0);

    // table no longer sorted
    queue_load(3, 100);
    queue_search(100);
    queue_search(0);
    settle();

    // random phases
    tally = 0;
    phase = 0;
    while (tally < RANDOM_OPS || phase < 4) begin
      in_idle = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      if (phase == 0) begin
        // whole table, so every later search reads loaded entries
        set_entry_count(CNT_W'(DEPTH));
        fill_sorted(DEPTH);
        run_searches(DEPTH, 40);
      end else if (phase == 1 || phase == 2) begin
        // count beyond the table depth
        set_entry_count(phase == 1 ? {CNT_W{1'b1}} :
                        CNT_W'($urandom_range(DEPTH + 1, 2046)));
        run_searches(DEPTH, 30);
      end else if (phase % 9 == 7) begin
        set_entry_count('0);
        run_searches(0, 6);
      end else begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
        set_entry_count(CNT_W'(n));
        // receiver holds off while the sender keeps pushing
        if (phase == 3 || phase == 12) begin
          in_idle = 1'b0;
          hold_req = 300;
        end
        fill_sorted(n);
        run_searches(n, $urandom_range(10, 40));
      end
      settle();
      phase++;
    end

    if (errors == 0) begin
      $display("sorted_table_binary_search_unit: match");
    end else begin
      $display("sorted_table_binary_search_unit: mismatch");
    end
    $finish;
  end

endmodule
